// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/pcs_pkg.sv =====
`default_nettype none

package pcs_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	localparam logic [CFG_W-1:0] SETTLE_RESET = CFG_W'(10);
	localparam logic [CFG_W-1:0] REVERSE_RESET = CFG_W'(800);

	localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE = CFG_INDEX_W'(1);

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_ARM     = 3'd1,
		PH_RAISE   = 3'd2,
		PH_OPEN    = 3'd3,
		PH_REVERSE = 3'd4,
		PH_CLOSE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		MOTOR_STOP  = 2'd0,
		MOTOR_OPEN  = 2'd1,
		MOTOR_CLOSE = 2'd2
	} motor_t;

	typedef struct packed {
		logic [CFG_W-1:0] settle_ticks;
		logic [CFG_W-1:0] reverse_ticks;
	} cfg_t;

	typedef struct packed {
		logic manual_switch;
		logic start_button;
		logic close_button;
		logic open_button;
		logic closed_limit;
		logic open_limit;
		logic upper_limit;
		logic lower_limit;
	} in_t;

	typedef struct packed {
		logic       valve_on;
		logic [1:0] motor_dir;
		logic       lamp_on;
		logic [2:0] phase;
		logic       press_done;
		logic       manual_active;
	} res_t;

	typedef struct packed {
		logic adv;
	} flow_t;

endpackage

`default_nettype wire

// ===== rtl/core/press_cycle_sequencer_core.sv =====
// press cycle sequencer
// input channel: in_valid/in_ready with one word per millisecond tick, carrying
//   the sampled switch, button and limit levels
// output channel: out_valid/out_ready, one result word per input word with the
//   valve, motor, lamp, phase, done pulse and manual flag after that tick
// config channel: cfg_valid/cfg_ready, cfg_index 0 settle ticks, 1 reverse
//   ticks; always ready, other indexes are dropped; write only while idle
// latency: result valid one cycle after the edge that takes the input word
// throughput: one word per cycle; the next-state logic sits between the input
//   register and the result register and updates phase, latches and timers
//   in the same cycle the result is loaded
// stall: while out_ready is low the result holds, one more word waits in the
//   input register, then in_ready drops
// reset: arst_n clears phase, valve, motor and both timers, loads the default
//   settle and reverse ticks and empties both registers
`default_nettype none

module press_cycle_sequencer_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic                            manual_switch,
	input  wire logic                            start_button,
	input  wire logic                            close_button,
	input  wire logic                            open_button,
	input  wire logic                            closed_limit,
	input  wire logic                            open_limit,
	input  wire logic                            upper_limit,
	input  wire logic                            lower_limit,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic                            valve_on,
	output      logic [1:0]                      motor_dir,
	output      logic                            lamp_on,
	output      logic [2:0]                      phase,
	output      logic                            press_done,
	output      logic                            manual_active,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pcs_pkg::CFG_W-1:0]       cfg_data
);
	import pcs_pkg::*;

	cfg_t  cfg;
	in_t   in_word;
	in_t   word_s1;
	flow_t flow;
	res_t  res;
	res_t  res_q;
	logic  out_busy;

	assign in_word.manual_switch = manual_switch;
	assign in_word.start_button = start_button;
	assign in_word.close_button = close_button;
	assign in_word.open_button = open_button;
	assign in_word.closed_limit = closed_limit;
	assign in_word.open_limit = open_limit;
	assign in_word.upper_limit = upper_limit;
	assign in_word.lower_limit = lower_limit;

	pcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_busy (out_busy),
		.flow     (flow),
		.word_s1  (word_s1)
	);

	pcs_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.flow    (flow),
		.word_s1 (word_s1),
		.cfg     (cfg),
		.res     (res)
	);

	pcs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (flow.adv),
		.res       (res),
		.out_busy  (out_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign valve_on = res_q.valve_on;
	assign motor_dir = res_q.motor_dir;
	assign lamp_on = res_q.lamp_on;
	assign phase = res_q.phase;
	assign press_done = res_q.press_done;
	assign manual_active = res_q.manual_active;

endmodule

`default_nettype wire

// ===== rtl/core/pcs_cfg_regs.sv =====
`default_nettype none

module pcs_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pcs_pkg::CFG_W-1:0]       cfg_data,
	output      pcs_pkg::cfg_t                   cfg
);
	import pcs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks <= SETTLE_RESET;
			cfg_q.reverse_ticks <= REVERSE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SETTLE) begin
				cfg_q.settle_ticks <= cfg_data;
			end else if (cfg_index == CFG_REVERSE) begin
				cfg_q.reverse_ticks <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcs_in_stage.sv =====
`default_nettype none

module pcs_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire pcs_pkg::in_t   in_word,
	input  wire logic           out_busy,
	output      pcs_pkg::flow_t flow,
	output      pcs_pkg::in_t   word_s1
);
	import pcs_pkg::*;

	logic valid_s1;
	logic adv;

	// a held word moves on when the result register is free or being emptied
	assign adv = valid_s1 && !out_busy;
	assign in_ready = !valid_s1 || adv;
	assign flow.adv = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcs_sequencer.sv =====
`default_nettype none

module pcs_sequencer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pcs_pkg::flow_t flow,
	input  wire pcs_pkg::in_t   word_s1,
	input  wire pcs_pkg::cfg_t  cfg,
	output      pcs_pkg::res_t  res
);
	import pcs_pkg::*;

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	phase_t                 phase_q, phase_d;
	logic                   valve_q, valve_d;
	motor_t                 motor_q, motor_d;
	logic [TIMER_WIDTH-1:0] rev_q, rev_d, rev_inc;
	logic [TIMER_WIDTH-1:0] set_q, set_d, set_inc;
	logic                   settle_ok, reverse_ok;
	logic                   done;

	// timers step first and saturate
	assign rev_inc = (rev_q == TIMER_MAX) ? rev_q : rev_q + TIMER_WIDTH'(1);
	assign set_inc = (set_q == TIMER_MAX) ? set_q : set_q + TIMER_WIDTH'(1);
	assign settle_ok = CMP_W'(set_inc) >= CMP_W'(cfg.settle_ticks);
	assign reverse_ok = CMP_W'(rev_inc) >= CMP_W'(cfg.reverse_ticks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			valve_q <= 1'b0;
			motor_q <= MOTOR_STOP;
			rev_q <= '0;
			set_q <= '0;
		end else if (flow.adv) begin
			phase_q <= phase_d;
			valve_q <= valve_d;
			motor_q <= motor_d;
			rev_q <= rev_d;
			set_q <= set_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		valve_d = valve_q;
		motor_d = motor_q;
		rev_d = rev_inc;
		set_d = set_inc;
		done = 1'b0;
		if (word_s1.manual_switch) begin
			valve_d = 1'b0;
			phase_d = PH_WAIT;
			if (word_s1.close_button && !word_s1.closed_limit) begin
				motor_d = MOTOR_CLOSE;
			end else if (word_s1.open_button && !word_s1.open_limit) begin
				motor_d = MOTOR_OPEN;
			end else begin
				motor_d = MOTOR_STOP;
			end
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (word_s1.closed_limit && word_s1.lower_limit && settle_ok) begin
						phase_d = PH_ARM;
					end
				end
				PH_ARM: begin
					if (word_s1.start_button) begin
						phase_d = PH_RAISE;
					end
				end
				PH_RAISE: begin
					valve_d = !word_s1.upper_limit;
					if (word_s1.upper_limit) begin
						phase_d = PH_OPEN;
					end
				end
				PH_OPEN: begin
					motor_d = MOTOR_OPEN;
					if (word_s1.open_limit || word_s1.lower_limit) begin
						motor_d = MOTOR_STOP;
						rev_d = '0;
						phase_d = PH_REVERSE;
					end
				end
				PH_REVERSE: begin
					if (word_s1.lower_limit && reverse_ok) begin
						motor_d = MOTOR_CLOSE;
						phase_d = PH_CLOSE;
					end
				end
				PH_CLOSE: begin
					if (word_s1.closed_limit) begin
						motor_d = MOTOR_STOP;
						phase_d = PH_WAIT;
						set_d = '0;
						done = 1'b1;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		res.valve_on = valve_d;
		res.motor_dir = motor_d;
		res.lamp_on = (phase_d == PH_ARM);
		res.phase = phase_d;
		res.press_done = done;
		res.manual_active = word_s1.manual_switch;
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcs_out_stage.sv =====
`default_nettype none

module pcs_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire pcs_pkg::res_t  res,
	output      logic           out_busy,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      pcs_pkg::res_t  res_q
);
	import pcs_pkg::*;

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcs_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module pcs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       valve_on,
	input wire logic [1:0] motor_dir,
	input wire logic       lamp_on,
	input wire logic [2:0] phase,
	input wire logic       press_done,
	input wire logic       manual_active
);
	import pcs_pkg::*;

	`ASSERT_IMPLIES(a_lamp_tracks_arm, out_valid, lamp_on == (phase == PH_ARM))
	`ASSERT_IMPLIES(a_manual_resets, out_valid && manual_active, !valve_on && phase == PH_WAIT && !press_done)
	`ASSERT_IMPLIES(a_done_stops, out_valid && press_done, phase == PH_WAIT && motor_dir == MOTOR_STOP && !manual_active)
	`ASSERT_IMPLIES(a_valve_only_raise, out_valid && valve_on, phase == PH_RAISE && motor_dir != MOTOR_CLOSE || phase == PH_RAISE)
	`ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(phase) && $stable(motor_dir))

endmodule

bind press_cycle_sequencer_core pcs_checker u_pcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.valve_on      (valve_on),
	.motor_dir     (motor_dir),
	.lamp_on       (lamp_on),
	.phase         (phase),
	.press_done    (press_done),
	.manual_active (manual_active)
);

`default_nettype wire
